FILE: design/fcnrw_pkg.sv
`default_nettype none

package fcnrw_pkg;

    // Channel count and queue depth
    localparam int NUM_CH      = 5;
    localparam int QUEUE_DEPTH = 2;

    // Chip register codes
    localparam logic [7:0] KEY_REG      = 8'h28;
    localparam logic [7:0] KEY_ON_BITS  = 8'hF0;
    localparam logic [7:0] FREQ_HI_REG  = 8'hA4;
    localparam logic [7:0] FREQ_LO_REG  = 8'hA0;
    localparam logic [7:0] LEVEL_REG    = 8'h40;
    localparam logic [7:0] SILENT_LEVEL = 8'd127;
    localparam logic [3:0] VOL_MAX      = 4'd15;

    // Write steps of one request, in output order
    localparam logic [2:0] STEP_KEY_OFF = 3'd0;
    localparam logic [2:0] STEP_FREQ_HI = 3'd1;
    localparam logic [2:0] STEP_FREQ_LO = 3'd2;
    localparam logic [2:0] STEP_LEVEL0  = 3'd3;
    localparam logic [2:0] STEP_KEY_ON  = 3'd7;

    // Step masks (bit n enables step n)
    localparam logic [7:0] MASK_RELEASE = 8'b0111_1001;
    localparam logic [7:0] MASK_LEVELS  = 8'b0111_1000;
    localparam logic [7:0] MASK_NOTE    = 8'b1111_1110;
    localparam logic [7:0] MASK_KEY_OFF = 8'b0000_0001;

    // Per channel, per operator base attenuation and volume scale
    localparam logic [5:0] BASE_ATTEN [0:NUM_CH-1][0:3] = '{
        '{6'd32, 6'd23, 6'd23, 6'd0},
        '{6'd15, 6'd28, 6'd30, 6'd11},
        '{6'd48, 6'd43, 6'd42, 6'd32},
        '{6'd44, 6'd39, 6'd38, 6'd28},
        '{6'd19, 6'd32, 6'd34, 6'd15}
    };

    localparam logic [2:0] VOL_SCALE [0:NUM_CH-1][0:3] = '{
        '{3'd0, 3'd0, 3'd1, 3'd6},
        '{3'd1, 3'd1, 3'd1, 3'd6},
        '{3'd1, 3'd1, 3'd2, 3'd3},
        '{3'd1, 3'd1, 3'd2, 3'd4},
        '{3'd1, 3'd1, 3'd1, 3'd5}
    };

    // Input item
    typedef struct packed {
        logic [2:0]  channel;
        logic [10:0] pitch_number;
        logic [2:0]  octave_block;
        logic [7:0]  volume;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic       bank;
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       last_write;
    } t_out_item;

    // Classified request handed from front to back
    typedef struct packed {
        logic [2:0]  channel;
        logic [10:0] pitch_number;
        logic [2:0]  octave_block;
        logic [3:0]  vol_clamped;
        logic [7:0]  steps;
    } t_cmd;

    // Operator level: silent at zero volume, else base - vol*scale floored at 0
    function automatic logic [7:0] level_of(input logic [2:0] ch, input logic [1:0] op,
                                            input logic [3:0] vol);
        logic [5:0] base;
        logic [6:0] prod;
        logic [7:0] tl;
        base = BASE_ATTEN[ch][op];
        prod = 7'(vol) * 7'(VOL_SCALE[ch][op]);
        if (vol == 4'd0) begin
            tl = SILENT_LEVEL;
        end else if (7'(base) > prod) begin
            tl = 8'(base - prod[5:0]);
        end else begin
            tl = 8'd0;
        end
        return tl;
    endfunction

endpackage

`default_nettype wire

FILE: design/fm_channel_note_register_writer_unit.sv
// Channel   Direction  Handshake         Payload
// request   in         i_valid/o_ready   i_item (t_in_item)
// write     out        o_valid/i_ready   o_item (t_out_item)
//
// A request is classified combinationally in the front and is queued (2 entries) when it needs writes.
// The back issues one register write per cycle while the output is not stalled:
// 0 to 8 writes per request; a request is popped when its last write is issued.
// Reset (i_rst_n low, synchronous) clears held channel state, queue and output.
// A stalled output holds its write; the front keeps accepting until the queue fills.
`default_nettype none

module fm_channel_note_register_writer_unit #(
    parameter int NUM_CHANNELS = fcnrw_pkg::NUM_CH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  fcnrw_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  wire                  i_ready,
    output fcnrw_pkg::t_out_item o_item
);
    import fcnrw_pkg::*;

    logic push, pop, full, head_valid;
    t_cmd push_cmd, head;

    assign o_ready = !full;

    // Request classification and held state
    fcnrw_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_room  (!full),
        .i_item  (i_item),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Command queue
    fcnrw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Write sequencer
    fcnrw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_item       (o_item)
    );

endmodule

`default_nettype wire

FILE: design/fcnrw_front.sv
`default_nettype none

module fcnrw_front #(
    parameter int NUM_CHANNELS = fcnrw_pkg::NUM_CH
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire                   i_room,
    input  fcnrw_pkg::t_in_item   i_item,
    output logic                  o_push,
    output fcnrw_pkg::t_cmd       o_cmd
);
    import fcnrw_pkg::*;

    localparam int CH_W = $clog2(NUM_CHANNELS);

    logic [10:0] r_held_pitch  [NUM_CHANNELS];
    logic [2:0]  r_held_block  [NUM_CHANNELS];
    logic [7:0]  r_held_volume [NUM_CHANNELS];

    logic [CH_W-1:0] idx;
    logic            ch_ok, accept;
    logic            want_on, was_on, pitch_chg, vol_chg;
    logic [7:0]      steps;
    logic [3:0]      vol_clamped;

    assign idx    = i_item.channel[CH_W-1:0];
    assign ch_ok  = i_item.channel < 3'(NUM_CHANNELS);
    assign accept = i_valid && i_room;

    // Classify the item against the channel's held state
    always_comb begin
        want_on   = (i_item.pitch_number != 11'd0) && (i_item.volume != 8'd0);
        was_on    = r_held_volume[idx] != 8'd0;
        pitch_chg = (r_held_pitch[idx] != i_item.pitch_number)
                 || (r_held_block[idx] != i_item.octave_block);
        vol_chg   = r_held_volume[idx] != i_item.volume;
        vol_clamped = (i_item.volume > 8'(VOL_MAX)) ? VOL_MAX : i_item.volume[3:0];
        steps = 8'd0;
        if (!want_on) begin
            vol_clamped = 4'd0;
            if (was_on) begin
                steps = MASK_RELEASE;
            end
        end else if (!was_on || pitch_chg) begin
            steps = MASK_NOTE | (was_on ? MASK_KEY_OFF : 8'd0);
        end else if (vol_chg) begin
            steps = MASK_LEVELS;
        end
    end

    assign o_push = accept && ch_ok && (steps != 8'd0);

    always_comb begin
        o_cmd.channel      = i_item.channel;
        o_cmd.pitch_number = i_item.pitch_number;
        o_cmd.octave_block = i_item.octave_block;
        o_cmd.vol_clamped  = vol_clamped;
        o_cmd.steps        = steps;
    end

    // Held state update; release clears the channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_held_pitch[i]  <= 11'd0;
                r_held_block[i]  <= 3'd0;
                r_held_volume[i] <= 8'd0;
            end
        end else if (accept && ch_ok) begin
            if (want_on) begin
                r_held_pitch[idx]  <= i_item.pitch_number;
                r_held_block[idx]  <= i_item.octave_block;
                r_held_volume[idx] <= i_item.volume;
            end else begin
                r_held_pitch[idx]  <= 11'd0;
                r_held_block[idx]  <= 3'd0;
                r_held_volume[idx] <= 8'd0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/fcnrw_queue.sv
`default_nettype none

module fcnrw_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  fcnrw_pkg::t_cmd  i_cmd,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output fcnrw_pkg::t_cmd  o_head
);
    import fcnrw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_slot[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/fcnrw_back.sv
`default_nettype none

module fcnrw_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_head_valid,
    input  fcnrw_pkg::t_cmd      i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output fcnrw_pkg::t_out_item o_item
);
    import fcnrw_pkg::*;

    // First enabled step at or after a start point: {found, step}
    function automatic logic [3:0] first_en(input logic [7:0] mask, input logic [3:0] from);
        logic       found;
        logic [2:0] s;
        found = 1'b0;
        s     = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (!found && (4'(k) >= from) && mask[k]) begin
                found = 1'b1;
                s     = 3'(k);
            end
        end
        return {found, s};
    endfunction

    logic [2:0] r_step;
    logic       r_out_valid;
    t_out_item  r_out;

    logic       f_cur, f_nxt, adv;
    logic [2:0] cur, nxt;
    logic       is_hi;
    logic [1:0] slot;
    logic [7:0] key_code;
    logic [1:0] op;
    t_out_item  wr;

    assign {f_cur, cur} = first_en(i_head.steps, {1'b0, r_step});
    assign {f_nxt, nxt} = first_en(i_head.steps, {1'b0, cur} + 4'd1);
    assign adv   = i_head_valid && f_cur && (!r_out_valid || i_ready);
    assign o_pop = adv && !f_nxt;

    // Register write for the current step
    always_comb begin
        is_hi    = i_head.channel >= 3'd3;
        slot     = is_hi ? 2'(i_head.channel - 3'd3) : i_head.channel[1:0];
        key_code = is_hi ? 8'(i_head.channel + 3'd1) : 8'(i_head.channel);
        op       = 2'(cur - STEP_LEVEL0);
        wr.bank        = is_hi;
        wr.last_write  = !f_nxt;
        wr.reg_address = LEVEL_REG + {4'd0, op, 2'b00} + 8'(slot);
        wr.reg_data    = level_of(i_head.channel, op, i_head.vol_clamped);
        case (cur)
            STEP_KEY_OFF: begin
                wr.bank        = 1'b0;
                wr.reg_address = KEY_REG;
                wr.reg_data    = key_code;
            end
            STEP_FREQ_HI: begin
                wr.reg_address = FREQ_HI_REG + 8'(slot);
                wr.reg_data    = {2'b00, i_head.octave_block, i_head.pitch_number[10:8]};
            end
            STEP_FREQ_LO: begin
                wr.reg_address = FREQ_LO_REG + 8'(slot);
                wr.reg_data    = i_head.pitch_number[7:0];
            end
            STEP_KEY_ON: begin
                wr.bank        = 1'b0;
                wr.reg_address = KEY_REG;
                wr.reg_data    = KEY_ON_BITS | key_code;
            end
            default: ;
        endcase
    end

    // Step pointer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_KEY_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_step      <= f_nxt ? nxt : STEP_KEY_OFF;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= wr;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

FILE: design/fcnrw_checker.sv
`default_nettype none

module fcnrw_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_valid,
    input wire                  i_ready,
    input fcnrw_pkg::t_out_item o_item
);
    import fcnrw_pkg::*;

    // Output is empty after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("write valid after reset");

    // Stalled write holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("stalled write changed");

    // Key writes always go to bank 0
    a_key_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.reg_address == KEY_REG |-> !o_item.bank)
        else $error("key write on bank 1");

    // Key-on ends its request
    a_key_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.reg_address == KEY_REG && o_item.reg_data[7:4] == 4'hF
        |-> o_item.last_write)
        else $error("key-on not last write");

    // Operator levels stay within 7 bits
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.reg_address[7:4] == 4'h4 |-> !o_item.reg_data[7])
        else $error("level out of range");

endmodule

bind fm_channel_note_register_writer_unit fcnrw_checker u_fcnrw_checker (.*);

`default_nettype wire
